[design/wzad_pkg.sv]
// Shared types, constants and codes for the z-score anomaly detector.
package wzad_pkg;

   // Default feature count and the fixed widths of the data path.
   localparam int FEATURE_COUNT_DEF = 3;
   localparam int THRESH_W          = 24;
   localparam int WARMUP_W          = 16;
   localparam int SCORE_W           = 24;
   localparam int COUNT_W           = 32;
   localparam int MEAN_W            = 32;
   localparam int M2_W              = 64;
   localparam int STEP_W            = 7;

   // Reset values of the configuration registers.
   localparam logic [THRESH_W-1:0] THRESH_RESET = 24'd768;
   localparam logic [WARMUP_W-1:0] WARMUP_RESET = 16'd10;

   // Saturation and skip limits.
   localparam logic [63:0]        VAR_MAX   = 64'h00FF_FFFF_FFFF_FFFF;
   localparam logic [SCORE_W-1:0] SCORE_MAX = 24'hFF_FFFF;
   localparam logic [31:0]        SD_MIN_Q8 = 32'd2;

   // Iteration counts of the shared unit.
   localparam logic [STEP_W-1:0] STEPS_LONG  = 7'd64;
   localparam logic [STEP_W-1:0] STEPS_SHORT = 7'd32;

   // Register indexes of the configuration port.
   localparam logic REG_THRESHOLD = 1'b0;
   localparam logic REG_WARMUP    = 1'b1;

   // Request kinds carried in tuser.
   localparam logic KIND_SAMPLE = 1'b0;
   localparam logic KIND_CLEAR  = 1'b1;

   // Feature slots.
   localparam logic [3:0] FEAT_QUERY  = 4'd0;
   localparam logic [3:0] FEAT_UNIQUE = 4'd1;
   localparam logic [3:0] FEAT_NEW    = 4'd2;

   // Operations of the shared divide and square-root unit.
   typedef enum logic {
      ALU_DIV  = 1'b0,
      ALU_SQRT = 1'b1
   } alu_op_type;

   // Command from the sequencer to the shared unit.
   typedef struct packed {
      logic              start;
      alu_op_type        op;
      logic [STEP_W-1:0] steps;
      logic [63:0]       operand;
      logic [31:0]       divisor;
   } alu_cmd_type;

   // Status returned by the shared unit.
   typedef struct packed {
      logic        busy;
      logic        done;
      logic [63:0] result;
   } alu_status_type;

   // Sequencer states.
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_FEAT,
      ST_VAR_WAIT,
      ST_SQRT_WAIT,
      ST_TERM_WAIT,
      ST_MEAN_WAIT,
      ST_MUL,
      ST_ACC,
      ST_OUT
   } state_type;

endpackage

[design/wzad_alu.sv]
// Shared bit-serial divider and square-root unit, one digit per cycle.
module wzad_alu (
   input  logic                    clock,
   input  logic                    reset,
   input  wzad_pkg::alu_cmd_type    cmd,
   output wzad_pkg::alu_status_type status
);

   logic                              busy_ff, busy_in;
   logic                              done_ff, done_in;
   wzad_pkg::alu_op_type              op_ff, op_in;
   logic [wzad_pkg::STEP_W-1:0]       cnt_ff, cnt_in;
   logic [63:0]                       acc_ff, acc_in;
   logic [34:0]                       rem_ff, rem_in;
   logic [31:0]                       root_ff, root_in;
   logic [31:0]                       div_ff, div_in;

   logic [34:0] sub_a;
   logic [34:0] sub_b;
   logic [34:0] sub_diff;
   logic        sub_ge;

   // One shared compare and subtract serves both operations.
   always_comb begin
      if (op_ff == wzad_pkg::ALU_SQRT) begin
         sub_a = {rem_ff[32:0], acc_ff[63:62]};
         sub_b = {1'b0, root_ff, 2'b01};
      end else begin
         sub_a = {2'b00, rem_ff[31:0], acc_ff[63]};
         sub_b = {3'b000, div_ff};
      end
      sub_ge   = (sub_a >= sub_b);
      sub_diff = sub_a - sub_b;
   end

   // Load on start, then one digit per cycle until the count runs out.
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      op_in   = op_ff;
      cnt_in  = cnt_ff;
      acc_in  = acc_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      div_in  = div_ff;
      if (cmd.start) begin
         busy_in = 1'b1;
         op_in   = cmd.op;
         cnt_in  = cmd.steps;
         acc_in  = cmd.operand;
         rem_in  = '0;
         root_in = '0;
         div_in  = cmd.divisor;
      end else if (busy_ff) begin
         rem_in = sub_ge ? sub_diff : sub_a;
         if (op_ff == wzad_pkg::ALU_SQRT) begin
            root_in = {root_ff[30:0], sub_ge};
            acc_in  = {acc_ff[61:0], 2'b00};
         end else begin
            acc_in = {acc_ff[62:0], sub_ge};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == wzad_pkg::STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      op_ff   <= op_in;
      cnt_ff  <= cnt_in;
      acc_ff  <= acc_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      div_ff  <= div_in;
   end

   // The quotient sits in the shift register, the root in its own register.
   assign status.busy   = busy_ff;
   assign status.done   = done_ff;
   assign status.result = (op_ff == wzad_pkg::ALU_SQRT) ? {32'd0, root_ff} : acc_ff;

endmodule

[design/welford_zscore_anomaly_detector.sv]
// Top level: running-statistics z-score anomaly detector over traffic-count windows.
//
//  channel | dir | handshake            | payload
//  req     | in  | req_tvalid/tready    | tdata: query, unique, new; tuser: kind
//  rsp     | out | rsp_tvalid/tready    | tdata: score, is_anomaly, warmed_up
//  csr     | in  | csr_valid/csr_ready  | csr_addr, csr_wdata
//
// A scored feature runs a start state, the 64-step variance divide, then the 32-step
// root, score divide and mean divide, then multiply and accumulate. The shared
// bit-serial divide and root unit serves every feature in turn. Before two samples a
// feature runs only the mean divide, multiply and accumulate, and a tiny standard
// deviation skips the score divide. Clear requests and empty windows are handled in the
// idle state, which the block does not leave. Reset is synchronous and clears the
// statistics at once. A stalled result holds in the output register; a new request is
// taken while it waits, and the next result waits for it.
module welford_zscore_anomaly_detector #(
   parameter int FEATURE_COUNT = wzad_pkg::FEATURE_COUNT_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // query_count[15:0], unique_count[22:16], new_count[29:23]
   input  logic        req_tuser,   // req_type[0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // score[23:0], is_anomaly[24], warmed_up[25]
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_addr,
   input  logic [23:0] csr_wdata
);

   localparam int FIDX_W = (FEATURE_COUNT > 1) ? $clog2(FEATURE_COUNT) : 1;

   wzad_pkg::state_type                 state_ff, state_in;
   logic [wzad_pkg::THRESH_W-1:0]       thresh_ff, thresh_in;
   logic [wzad_pkg::WARMUP_W-1:0]       warmup_ff, warmup_in;
   logic [wzad_pkg::COUNT_W-1:0]        count_ff, count_in;
   logic [wzad_pkg::WARMUP_W-1:0]       absorbed_ff, absorbed_in;
   logic [wzad_pkg::MEAN_W-1:0]         mean_ff [FEATURE_COUNT];
   logic [wzad_pkg::MEAN_W-1:0]         mean_in [FEATURE_COUNT];
   logic [wzad_pkg::M2_W-1:0]           m2_ff [FEATURE_COUNT];
   logic [wzad_pkg::M2_W-1:0]           m2_in [FEATURE_COUNT];
   logic [FIDX_W-1:0]                   feat_ff, feat_in;
   logic [15:0]                         query_ff, query_in;
   logic [6:0]                          unique_ff, unique_in;
   logic [6:0]                          new_ff, new_in;
   logic                                warm_ff, warm_in;
   logic [wzad_pkg::SCORE_W-1:0]        sum_ff, sum_in;
   logic [31:0]                         dabs_ff, dabs_in;
   logic [31:0]                         ndiff_ff, ndiff_in;
   logic [63:0]                         prod_ff, prod_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   logic [25:0]                         rsp_data_ff, rsp_data_in;

   wzad_pkg::alu_cmd_type    alu_cmd;
   wzad_pkg::alu_status_type alu_stat;

   logic                     req_fire;
   logic [3:0]               feat_wide;
   logic [15:0]              x_cur;
   logic [31:0]              xs;
   logic [31:0]              mean_cur;
   logic [63:0]              m2_cur;
   logic                     dneg;
   logic [31:0]              dabs;
   logic [31:0]              n_new;
   logic                     last_feat;
   logic [63:0]              var_clamped;
   logic [31:0]              new_mean;
   logic [32:0]              score_sum;
   logic [64:0]              m2_sum;
   logic                     anomaly;

   wzad_alu u_alu (
      .clock  (clock),
      .reset  (reset),
      .cmd    (alu_cmd),
      .status (alu_stat)
   );

   assign req_tready = (state_ff == wzad_pkg::ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   // Current feature value, its deviation from the stored mean, and the new count.
   always_comb begin
      feat_wide = 4'(feat_ff);
      case (feat_wide)
         wzad_pkg::FEAT_QUERY:  x_cur = query_ff;
         wzad_pkg::FEAT_UNIQUE: x_cur = {9'd0, unique_ff};
         wzad_pkg::FEAT_NEW:    x_cur = {9'd0, new_ff};
         default:               x_cur = 16'd0;
      endcase
      xs          = {x_cur, 16'd0};
      mean_cur    = mean_ff[feat_ff];
      m2_cur      = m2_ff[feat_ff];
      dneg        = (mean_cur > xs);
      dabs        = dneg ? (mean_cur - xs) : (xs - mean_cur);
      n_new       = (count_ff == '1) ? count_ff : (count_ff + 1'b1);
      last_feat   = (feat_ff == FIDX_W'(FEATURE_COUNT - 1));
      var_clamped = (alu_stat.result > wzad_pkg::VAR_MAX) ? wzad_pkg::VAR_MAX
                                                           : alu_stat.result;
      new_mean    = dneg ? (mean_cur - alu_stat.result[31:0])
                         : (mean_cur + alu_stat.result[31:0]);
      score_sum   = {9'd0, sum_ff} + {1'b0, alu_stat.result[31:0]};
      m2_sum      = {1'b0, m2_cur} + {25'd0, prod_ff[63:24]};
      anomaly     = warm_ff && (sum_ff > thresh_ff);
   end

   // Sequencer: next state, statistic updates and shared-unit commands.
   always_comb begin
      state_in     = state_ff;
      thresh_in    = thresh_ff;
      warmup_in    = warmup_ff;
      count_in     = count_ff;
      absorbed_in  = absorbed_ff;
      mean_in      = mean_ff;
      m2_in        = m2_ff;
      feat_in      = feat_ff;
      query_in     = query_ff;
      unique_in    = unique_ff;
      new_in       = new_ff;
      warm_in      = warm_ff;
      sum_in       = sum_ff;
      dabs_in      = dabs_ff;
      ndiff_in     = ndiff_ff;
      prod_in      = prod_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      alu_cmd      = '0;

      // Configuration writes.
      if (csr_valid && csr_ready) begin
         unique case (csr_addr)
            wzad_pkg::REG_THRESHOLD: thresh_in = csr_wdata;
            wzad_pkg::REG_WARMUP:    warmup_in = csr_wdata[wzad_pkg::WARMUP_W-1:0];
            default:                 thresh_in = thresh_ff;
         endcase
      end

      // The result register empties on a transfer.
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         wzad_pkg::ST_IDLE: begin
            if (req_fire) begin
               if (req_tuser == wzad_pkg::KIND_CLEAR) begin
                  count_in    = '0;
                  absorbed_in = '0;
                  for (int i = 0; i < FEATURE_COUNT; i++) begin
                     mean_in[i] = '0;
                     m2_in[i]   = '0;
                  end
               end else if (req_tdata[15:0] != 16'd0) begin
                  query_in  = req_tdata[15:0];
                  unique_in = req_tdata[22:16];
                  new_in    = req_tdata[29:23];
                  warm_in   = (absorbed_ff >= warmup_ff);
                  sum_in    = '0;
                  feat_in   = '0;
                  state_in  = wzad_pkg::ST_FEAT;
               end
            end
         end
         wzad_pkg::ST_FEAT: begin
            alu_cmd.start = 1'b1;
            alu_cmd.op    = wzad_pkg::ALU_DIV;
            if (count_ff >= 32'd2) begin
               alu_cmd.steps   = wzad_pkg::STEPS_LONG;
               alu_cmd.operand = m2_cur;
               alu_cmd.divisor = count_ff - 1'b1;
               state_in        = wzad_pkg::ST_VAR_WAIT;
            end else begin
               alu_cmd.steps   = wzad_pkg::STEPS_SHORT;
               alu_cmd.operand = {dabs, 32'd0};
               alu_cmd.divisor = n_new;
               state_in        = wzad_pkg::ST_MEAN_WAIT;
            end
         end
         wzad_pkg::ST_VAR_WAIT: begin
            if (alu_stat.done) begin
               alu_cmd.start   = 1'b1;
               alu_cmd.op      = wzad_pkg::ALU_SQRT;
               alu_cmd.steps   = wzad_pkg::STEPS_SHORT;
               alu_cmd.operand = {var_clamped[55:0], 8'd0};
               state_in        = wzad_pkg::ST_SQRT_WAIT;
            end
         end
         wzad_pkg::ST_SQRT_WAIT: begin
            if (alu_stat.done) begin
               alu_cmd.start   = 1'b1;
               alu_cmd.op      = wzad_pkg::ALU_DIV;
               alu_cmd.steps   = wzad_pkg::STEPS_SHORT;
               alu_cmd.operand = {dabs, 32'd0};
               // A tiny standard deviation skips the score term.
               if (alu_stat.result[31:0] > wzad_pkg::SD_MIN_Q8) begin
                  alu_cmd.divisor = alu_stat.result[31:0];
                  state_in        = wzad_pkg::ST_TERM_WAIT;
               end else begin
                  alu_cmd.divisor = n_new;
                  state_in        = wzad_pkg::ST_MEAN_WAIT;
               end
            end
         end
         wzad_pkg::ST_TERM_WAIT: begin
            if (alu_stat.done) begin
               sum_in = (score_sum > {9'd0, wzad_pkg::SCORE_MAX}) ? wzad_pkg::SCORE_MAX
                                                                   : score_sum[23:0];
               alu_cmd.start   = 1'b1;
               alu_cmd.op      = wzad_pkg::ALU_DIV;
               alu_cmd.steps   = wzad_pkg::STEPS_SHORT;
               alu_cmd.operand = {dabs, 32'd0};
               alu_cmd.divisor = n_new;
               state_in        = wzad_pkg::ST_MEAN_WAIT;
            end
         end
         wzad_pkg::ST_MEAN_WAIT: begin
            if (alu_stat.done) begin
               mean_in[feat_ff] = new_mean;
               dabs_in          = dabs;
               ndiff_in         = (new_mean > xs) ? (new_mean - xs) : (xs - new_mean);
               state_in         = wzad_pkg::ST_MUL;
            end
         end
         wzad_pkg::ST_MUL: begin
            prod_in  = 64'(dabs_ff) * 64'(ndiff_ff);
            state_in = wzad_pkg::ST_ACC;
         end
         wzad_pkg::ST_ACC: begin
            m2_in[feat_ff] = m2_sum[64] ? '1 : m2_sum[63:0];
            if (last_feat) begin
               count_in    = n_new;
               absorbed_in = (absorbed_ff == '1) ? absorbed_ff : (absorbed_ff + 1'b1);
               state_in    = wzad_pkg::ST_OUT;
            end else begin
               feat_in  = feat_ff + 1'b1;
               state_in = wzad_pkg::ST_FEAT;
            end
         end
         wzad_pkg::ST_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {warm_ff, anomaly, sum_ff};
               state_in     = wzad_pkg::ST_IDLE;
            end
         end
         default: state_in = wzad_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= wzad_pkg::ST_IDLE;
         thresh_ff    <= wzad_pkg::THRESH_RESET;
         warmup_ff    <= wzad_pkg::WARMUP_RESET;
         count_ff     <= '0;
         absorbed_ff  <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < FEATURE_COUNT; i++) begin
            mean_ff[i] <= '0;
            m2_ff[i]   <= '0;
         end
      end else begin
         state_ff     <= state_in;
         thresh_ff    <= thresh_in;
         warmup_ff    <= warmup_in;
         count_ff     <= count_in;
         absorbed_ff  <= absorbed_in;
         rsp_valid_ff <= rsp_valid_in;
         mean_ff      <= mean_in;
         m2_ff        <= m2_in;
      end
      feat_ff     <= feat_in;
      query_ff    <= query_in;
      unique_ff   <= unique_in;
      new_ff      <= new_in;
      warm_ff     <= warm_in;
      sum_ff      <= sum_in;
      dabs_ff     <= dabs_in;
      ndiff_ff    <= ndiff_in;
      prod_ff     <= prod_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, rsp_data_ff};

   // The shared unit is never restarted while it is still iterating.
   a_alu_start_idle: assert property (@(posedge clock) disable iff (reset)
      alu_cmd.start |-> !alu_stat.busy)
      else $error("shared unit started while busy");

   // A nonempty sample window makes the block busy on the next cycle.
   a_busy_after_sample: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_tuser == wzad_pkg::KIND_SAMPLE && req_tdata[15:0] != 16'd0)
      |=> !req_tready)
      else $error("block ready right after taking a sample window");

   // Absorbed windows never run ahead of the sample count.
   a_count_order: assert property (@(posedge clock) disable iff (reset)
      32'(absorbed_ff) <= count_ff)
      else $error("absorbed window count above sample count");

   // An anomaly is only flagged once warmed up.
   a_anomaly_warm: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (!rsp_data_ff[24] || rsp_data_ff[25]))
      else $error("anomaly flagged before warm-up");

endmodule

[bench/tb_welford_zscore_anomaly_detector.sv]
// Testbench for the running-statistics z-score anomaly detector, self-checking.
`timescale 1ns / 1ps

module tb_welford_zscore_anomaly_detector;

   localparam int HOLD_CYCLES  = 3000;
   localparam int SETTLE       = 700;
   localparam int CYCLE_LIMIT  = 4000000;
   localparam int PHASE_ITEMS  = 255;

   // One scored window as seen on the result channel.
   typedef struct {
      logic [23:0] score;
      logic        anomaly;
      logic        warm;
   } score_type;

   // One row of the directed stimulus table.
   typedef struct {
      logic        kind;
      logic [15:0] queries;
      logic [6:0]  uniques;
      logic [6:0]  fresh;
      bit          typed;
      score_type   want;
   } stim_row_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;
   logic        req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;
   logic        csr_valid;
   logic        csr_ready;
   logic        csr_addr;
   logic [23:0] csr_wdata;

   // Predictor state and its copy of the registers.
   logic [31:0] stat_count;
   logic [31:0] stat_mean [3];
   logic [63:0] stat_m2 [3];
   logic [15:0] stat_absorbed;
   logic [23:0] cfg_threshold;
   logic [15:0] cfg_warmup;

   score_type pending_scores [$];
   int     error_count;
   int     cycle_count;
   int     scores_seen;
   int     anomalies_seen;
   int     requests_sent;
   bit     idle_on;
   bit     long_hold_req;

   welford_zscore_anomaly_detector dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   // Free-running clock.
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic logic [63:0] abs_gap(logic [63:0] a, logic [63:0] b);
      return (a >= b) ? a - b : b - a;
   endfunction

   // Integer square root, bit by bit from the top.
   function automatic logic [63:0] int_root(logic [63:0] v);
      logic [63:0] r;
      logic [63:0] b;
      r = 64'd0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   task automatic clear_stats();
      stat_count    = 32'd0;
      stat_absorbed = 16'd0;
      for (int i = 0; i < 3; i++) begin
         stat_mean[i] = 32'd0;
         stat_m2[i]   = 64'd0;
      end
   endtask

   // Scores one accepted request and folds it into the statistics.
   task automatic score_and_absorb(input logic kind, input logic [15:0] q,
                                   input logic [6:0] u, input logic [6:0] n,
                                   output bit produced, output score_type res);
      logic [63:0] x [3];
      logic [63:0] sum;
      logic [63:0] var_q;
      logic [63:0] sd;
      logic [63:0] prod;
      logic [64:0] acc;
      longint      xs;
      longint      delta;
      longint      nm;
      bit          warm;
      produced = 0;
      res = '{score: 24'd0, anomaly: 1'b0, warm: 1'b0};
      if (kind == wzad_pkg::KIND_CLEAR) begin
         clear_stats();
         return;
      end
      if (q == 16'd0) return;
      x[0] = {48'd0, q};
      x[1] = {57'd0, u};
      x[2] = {57'd0, n};
      // Score against the statistics so far.
      sum = 64'd0;
      if (stat_count >= 32'd2) begin
         for (int i = 0; i < 3; i++) begin
            var_q = stat_m2[i] / {32'd0, stat_count - 32'd1};
            if (var_q > wzad_pkg::VAR_MAX) var_q = wzad_pkg::VAR_MAX;
            sd = int_root(var_q << 8);
            if (sd > {32'd0, wzad_pkg::SD_MIN_Q8}) begin
               sum = sum + abs_gap(x[i] << 16, {32'd0, stat_mean[i]}) / sd;
               if (sum > {40'd0, wzad_pkg::SCORE_MAX}) sum = {40'd0, wzad_pkg::SCORE_MAX};
            end
         end
      end
      warm = (stat_absorbed >= cfg_warmup);
      // Welford update of mean and M2.
      if (stat_count != 32'hFFFF_FFFF) stat_count = stat_count + 32'd1;
      for (int i = 0; i < 3; i++) begin
         xs    = longint'(x[i] << 16);
         delta = xs - longint'({32'd0, stat_mean[i]});
         nm    = longint'({32'd0, stat_mean[i]}) + delta / longint'({32'd0, stat_count});
         if (nm < 0) nm = 0;
         if (nm > longint'(64'h0000_0000_FFFF_FFFF)) nm = longint'(64'h0000_0000_FFFF_FFFF);
         stat_mean[i] = nm[31:0];
         prod = abs_gap(xs, {32'd0, stat_mean[i]}) * abs_gap(xs, xs - delta);
         prod = prod >> 24;
         acc  = {1'b0, stat_m2[i]} + {1'b0, prod};
         stat_m2[i] = acc[64] ? 64'hFFFF_FFFF_FFFF_FFFF : acc[63:0];
      end
      if (stat_absorbed != 16'hFFFF) stat_absorbed = stat_absorbed + 16'd1;
      produced    = 1;
      res.score   = sum[23:0];
      res.warm    = warm;
      res.anomaly = warm && (sum[23:0] > cfg_threshold);
   endtask

   // Offers one request after a random gap and records the expected score.
   task automatic send_request(input logic kind, input logic [15:0] q,
                               input logic [6:0] u, input logic [6:0] n,
                               input bit typed, input score_type want);
      int        gap;
      bit        produced;
      score_type res;
      gap = idle_on ? $urandom_range(0, 7) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {2'b00, n, u, q};
      do @(posedge clock); while (!req_tready);
      requests_sent++;
      score_and_absorb(kind, q, u, n, produced, res);
      if (produced) pending_scores.push_back(typed ? want : res);
   endtask

   // Lowers the request valid and waits until every score has come back.
   task automatic drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_scores.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_reg(input logic addr, input logic [23:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      if (addr == wzad_pkg::REG_THRESHOLD) cfg_threshold = value;
      else cfg_warmup = value[15:0];
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Random window: mostly near a baseline, with spikes, empties and clears.
   task automatic random_request(input int base_q, input int base_u, input int base_n);
      int          pick;
      logic        kind;
      logic [15:0] q;
      logic [6:0]  u;
      logic [6:0]  n;
      score_type   none;
      none = '{score: 24'd0, anomaly: 1'b0, warm: 1'b0};
      pick = $urandom_range(0, 99);
      kind = wzad_pkg::KIND_SAMPLE;
      q = 16'(base_q + $urandom_range(0, 8));
      u = 7'(base_u + $urandom_range(0, 3));
      n = 7'(base_n + $urandom_range(0, 2));
      if (pick < 1) begin
         kind = wzad_pkg::KIND_CLEAR;
         q = 16'($urandom);
      end else if (pick < 4) begin
         q = 16'd0;
      end else if (pick < 12) begin
         q = 16'($urandom);
         u = 7'($urandom_range(0, 127));
         n = 7'($urandom_range(0, 127));
      end else if (pick < 16) begin
         u = 7'($urandom_range(0, 64));
         n = 7'($urandom_range(0, 64));
      end
      send_request(kind, q, u, n, 0, none);
   endtask

   // Receiver: random stalls per result, plus one long hold on request.
   initial begin
      int w;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold_req) begin
            long_hold_req = 0;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         w = idle_on ? $urandom_range(0, 7) : 0;
         if (w > 0) begin
            rsp_tready <= 1'b0;
            repeat (w) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   // Result checker against the oldest expected score.
   always @(posedge clock) begin
      score_type exp_s;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_scores.size() == 0) begin
            $error("unexpected score: tdata=%h", rsp_tdata);
            error_count++;
         end else begin
            exp_s = pending_scores.pop_front();
            scores_seen++;
            if (rsp_tdata[24]) anomalies_seen++;
            if (rsp_tdata[23:0] !== exp_s.score) begin
               $error("score: expected %0d, actual %0d", exp_s.score, rsp_tdata[23:0]);
               error_count++;
            end
            if (rsp_tdata[24] !== exp_s.anomaly) begin
               $error("is_anomaly: expected %0d, actual %0d", exp_s.anomaly, rsp_tdata[24]);
               error_count++;
            end
            if (rsp_tdata[25] !== exp_s.warm) begin
               $error("warmed_up: expected %0d, actual %0d", exp_s.warm, rsp_tdata[25]);
               error_count++;
            end
         end
      end
   end

   // Run limit.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d scores pending", cycle_count,
                  pending_scores.size());
         $display("TEST FAILED");
         $finish;
      end
   end

   // Main sequence: reset, directed table, then random phases per setting.
   initial begin
      stim_row_type rows [$];
      score_type    zero_s;
      logic [23:0]  thresholds [4];
      logic [15:0]  warmups [4];
      int           bq;
      int           bu;
      int           bn;
      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tdata     = 32'd0;
      req_tuser     = wzad_pkg::KIND_SAMPLE;
      csr_valid     = 1'b0;
      csr_addr      = wzad_pkg::REG_THRESHOLD;
      csr_wdata     = 24'd0;
      error_count   = 0;
      cycle_count   = 0;
      scores_seen   = 0;
      anomalies_seen = 0;
      requests_sent = 0;
      idle_on       = 1;
      long_hold_req = 0;
      cfg_threshold = wzad_pkg::THRESH_RESET;
      cfg_warmup    = wzad_pkg::WARMUP_RESET;
      clear_stats();
      zero_s = '{score: 24'd0, anomaly: 1'b0, warm: 1'b0};

      // Directed table; typed rows are the first two samples after a clear.
      rows = '{
         '{wzad_pkg::KIND_SAMPLE, 16'd1,     7'd0,   7'd0,   1, zero_s},
         '{wzad_pkg::KIND_SAMPLE, 16'hFFFF,  7'd127, 7'd127, 1, zero_s},
         '{wzad_pkg::KIND_SAMPLE, 16'd0,     7'd5,   7'd5,   0, zero_s},
         '{wzad_pkg::KIND_SAMPLE, 16'd100,   7'd10,  7'd5,   0, zero_s},
         '{wzad_pkg::KIND_SAMPLE, 16'd100,   7'd10,  7'd5,   0, zero_s},
         '{wzad_pkg::KIND_SAMPLE, 16'd100,   7'd64,  7'd64,  0, zero_s},
         '{wzad_pkg::KIND_CLEAR,  16'hFFFF,  7'd127, 7'd127, 0, zero_s},
         '{wzad_pkg::KIND_SAMPLE, 16'd7,     7'd1,   7'd1,   1, zero_s},
         '{wzad_pkg::KIND_SAMPLE, 16'd7,     7'd1,   7'd1,   1, zero_s},
         '{wzad_pkg::KIND_SAMPLE, 16'd7,     7'd1,   7'd1,   0, zero_s},
         '{wzad_pkg::KIND_SAMPLE, 16'hFFFF,  7'd0,   7'd0,   0, zero_s},
         '{wzad_pkg::KIND_SAMPLE, 16'd50,    7'd20,  7'd10,  0, zero_s},
         '{wzad_pkg::KIND_SAMPLE, 16'd52,    7'd21,  7'd11,  0, zero_s},
         '{wzad_pkg::KIND_SAMPLE, 16'd48,    7'd19,  7'd9,   0, zero_s},
         '{wzad_pkg::KIND_SAMPLE, 16'd51,    7'd20,  7'd10,  0, zero_s},
         '{wzad_pkg::KIND_SAMPLE, 16'd49,    7'd20,  7'd10,  0, zero_s},
         '{wzad_pkg::KIND_SAMPLE, 16'd50,    7'd21,  7'd10,  0, zero_s},
         '{wzad_pkg::KIND_SAMPLE, 16'd50,    7'd20,  7'd11,  0, zero_s},
         '{wzad_pkg::KIND_SAMPLE, 16'hFFFF,  7'd64,  7'd64,  0, zero_s},
         '{wzad_pkg::KIND_SAMPLE, 16'd0,     7'd0,   7'd0,   0, zero_s},
         '{wzad_pkg::KIND_SAMPLE, 16'd50,    7'd0,   7'd127, 0, zero_s},
         '{wzad_pkg::KIND_CLEAR,  16'd0,     7'd0,   7'd0,   0, zero_s},
         '{wzad_pkg::KIND_SAMPLE, 16'd1,     7'd64,  7'd0,   1, zero_s}
      };

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (rows[i])
         send_request(rows[i].kind, rows[i].queries, rows[i].uniques, rows[i].fresh,
                      rows[i].typed, rows[i].want);
      for (int k = 0; k < PHASE_ITEMS; k++) random_request(200, 20, 5);

      // Threshold and warm-up settings, extremes included.
      thresholds[0] = 24'd0;        warmups[0] = 16'd0;
      thresholds[1] = 24'hFFFFFF;   warmups[1] = 16'hFFFF;
      thresholds[2] = 24'd256;      warmups[2] = 16'd3;
      thresholds[3] = 24'($urandom_range(128, 2048));
      warmups[3]    = 16'($urandom_range(0, 40));

      for (int p = 0; p < 4; p++) begin
         drain();
         write_reg(wzad_pkg::REG_THRESHOLD, thresholds[p]);
         write_reg(wzad_pkg::REG_WARMUP, {8'd0, warmups[p]});
         bq = $urandom_range(1, 60000);
         bu = $urandom_range(0, 60);
         bn = $urandom_range(0, 60);
         // Second phase: long receiver hold while requests keep coming.
         if (p == 1) begin
            idle_on = 0;
            long_hold_req = 1;
         end
         // Third phase runs without any idling on either side.
         if (p == 2) idle_on = 0;
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            if (p == 1 && k == 40) idle_on = 1;
            random_request(bq, bu, bn);
         end
         idle_on = 1;
      end

      drain();
      $display("Covered %0d requests, %0d scores (%0d anomalies) over five register settings.",
               requests_sent, scores_seen, anomalies_seen);
      $display("Included clears, empty windows, long result hold and idle-free stretches.");
      if (error_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
